/* rtl/pgr_pkg.sv */
`default_nettype none
package pgr_pkg;

   localparam int FONT_SLOTS  = 4;
   localparam int GLYPH_BYTES = 8192;
   localparam int CHAR_COUNT  = 256;

   localparam int BYTE_BITS   = 8;
   localparam int NIBBLE_MASK = 'hf;

   // Address widths of the two font stores.
   localparam int SIZE_DEPTH  = FONT_SLOTS * CHAR_COUNT;
   localparam int SIZE_AW     = $clog2(SIZE_DEPTH);
   localparam int GLYPH_DEPTH = FONT_SLOTS * GLYPH_BYTES;
   localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
   localparam int GADDR_W     = $clog2(GLYPH_BYTES);
   localparam int CIDX_W      = $clog2(CHAR_COUNT);

   // Bit offsets: at most CHAR_COUNT * 232 plus one glyph, kept with margin.
   localparam int OFF_W       = 18;

   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 72;

   localparam logic [1:0] OP_LOAD_SIZE  = 2'd0;
   localparam logic [1:0] OP_LOAD_GLYPH = 2'd1;
   localparam logic [1:0] OP_DRAW       = 2'd2;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_UNKNOWN_CHAR  = 2'd2;

   typedef enum logic [1:0] {
      KIND_SIZE  = 2'd0,
      KIND_GLYPH = 2'd1,
      KIND_DRAW  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic [1:0]   font_slot;
      logic [7:0]   char_code;
      logic [7:0]   size_byte;
      logic [12:0]  glyph_addr;
      logic [7:0]   glyph_byte;
      logic [12:0]  pos_x;
      logic [12:0]  pos_y;
      logic [23:0]  color;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type ent;
   } qout_type;

   typedef struct packed {
      logic pop;
      logic busy_clear;
   } bstat_type;

   function automatic logic glyph_present(input logic [7:0] s);
      return (s[7:4] != 4'd0) && (s[3:0] != 4'd0);
   endfunction

endpackage
`default_nettype wire

/* rtl/packed_glyph_rasterizer.sv */
`default_nettype none
// A load request is held in the request queue and written to its font store when the idle
// back end pops it. A draw request looks up the size byte of its code and, if no glyph is
// present, of the unknown-character code; it then walks the size table up to the code drawn
// after any fallback, then reads and emits each glyph row. The back end handles one request
// at a time. Reset is synchronous, active high; then a pass over all 1024 entries clears
// the size table while req_tready stays low. Configuration writes are taken at any time.
module packed_glyph_rasterizer import pgr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata from bit 0: font_slot, char_code, size_byte, glyph_addr, glyph_byte,
   // pos_x, pos_y, color, zero fill.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: op.
   input  wire logic [1:0]            req_tuser,
   // Response channel, one per glyph row.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata from bit 0: row_x, row_y, pixel_mask, pixel_color, zero fill.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // tlast: last_row.
   output logic                       rsp_tlast,
   // tuser: addr_overflow.
   output logic                       rsp_tuser,
   // Configuration write port.
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [11:0]           csr_wdata
);

   // The front end decodes each request, drops the ones that have no effect
   // and queues the rest; the back end owns both font stores and the
   // sequencer that walks the size table and streams the glyph rows.
   qout_type  qout;
   bstat_type bstat;

   pgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .bstat      (bstat),
      .qout       (qout)
   );

   pgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .qout       (qout),
      .bstat      (bstat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

/* rtl/pgr_ram.sv */
`default_nettype none
module pgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

/* rtl/pgr_front.sv */
`default_nettype none
module pgr_front import pgr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire bstat_type             bstat,
   output qout_type                   qout
);

   // Two-entry request queue; requests that do nothing are dropped here.
   qent_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   qent_type ent;
   logic     keep;
   logic     accept;
   logic     push;

   always_comb begin
      ent.font_slot  = req_tdata[1:0];
      ent.char_code  = req_tdata[9:2];
      ent.size_byte  = req_tdata[17:10];
      ent.glyph_addr = req_tdata[30:18];
      ent.glyph_byte = req_tdata[38:31];
      ent.pos_x      = req_tdata[51:39];
      ent.pos_y      = req_tdata[64:52];
      ent.color      = req_tdata[88:65];
      ent.kind       = KIND_DRAW;
      keep           = 1'b0;
      case (req_tuser)
         OP_LOAD_SIZE: begin
            ent.kind = KIND_SIZE;
            keep     = (32'(ent.char_code) < CHAR_COUNT);
         end
         OP_LOAD_GLYPH: begin
            ent.kind = KIND_GLYPH;
            keep     = (32'(ent.glyph_addr) < GLYPH_BYTES);
         end
         OP_DRAW: begin
            ent.kind = KIND_DRAW;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      if (32'(ent.font_slot) >= FONT_SLOTS) begin
         keep = 1'b0;
      end
   end

   assign req_tready = (cnt_ff != 2'd2) && !bstat.busy_clear;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (bstat.pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !bstat.pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && bstat.pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

   assign qout.valid = (cnt_ff != 2'd0);
   assign qout.ent   = mem_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      bstat.pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !bstat.pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost an entry");

endmodule
`default_nettype wire

/* rtl/pgr_back.sv */
`default_nettype none
module pgr_back import pgr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [11:0]           csr_wdata,
   input  wire qout_type              qout,
   output bstat_type                  bstat,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_LOOK1 = 7'b0000100,
      ST_LOOK2 = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_ROW   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [SIZE_AW-1:0] clr_ff, clr_in;
   logic [11:0]      sw_ff, sh_ff;
   logic [7:0]       unk_ff;
   logic [1:0]       slot_ff, slot_in;
   logic [7:0]       ch_ff, ch_in;
   logic             code_ok_ff, code_ok_in;
   logic [12:0]      px_ff, px_in, py_ff, py_in;
   logic [23:0]      color_ff, color_in;
   logic [7:0]       size_ff, size_in;
   logic [8:0]       i_ff, i_in;
   logic             pend_ff, pend_in;
   logic [OFF_W-1:0] off_ff, off_in, rowbit_ff, rowbit_in;
   logic [3:0]       dy_ff, dy_in;
   logic [1:0]       k_ff, k_in;
   logic [23:0]      win_ff, win_in;
   logic             ov_ff, ov_in;
   logic [12:0]      ox_ff, ox_in;
   logic [13:0]      oy_ff, oy_in;
   logic [14:0]      om_ff, om_in;
   logic [23:0]      oc_ff, oc_in;
   logic             ol_ff, ol_in, oo_ff, oo_in;

   logic               s_we;
   logic [SIZE_AW-1:0] s_addr;
   logic [7:0]         s_wdata, s_rdata;
   logic                g_we;
   logic [GLYPH_AW-1:0] g_addr;
   logic [7:0]          g_rdata;

   pgr_ram #(.WIDTH(8), .DEPTH(SIZE_DEPTH)) u_size (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
   pgr_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph (
      .clock(clock), .we(g_we), .addr(g_addr), .wdata(qout.ent.glyph_byte),
      .rdata(g_rdata));

   function automatic logic [SIZE_AW-1:0] size_addr(input logic [1:0] slot,
                                                    input logic [7:0] idx);
      return SIZE_AW'(SIZE_AW'(slot) * SIZE_AW'(CHAR_COUNT) + SIZE_AW'(idx));
   endfunction

   function automatic logic [GLYPH_AW-1:0] glyph_addr(input logic [1:0] slot,
                                                      input logic [GADDR_W-1:0] a);
      return GLYPH_AW'(GLYPH_AW'(slot) * GLYPH_AW'(GLYPH_BYTES) + GLYPH_AW'(a));
   endfunction

   function automatic logic [3:0] size_look_w(input logic [7:0] s);
      return s[3:0] & 4'(NIBBLE_MASK);
   endfunction

   function automatic logic [3:0] size_look_h(input logic [7:0] s);
      return s[7:4] & 4'(NIBBLE_MASK);
   endfunction

   logic             out_free;
   logic [7:0]       s_look;
   logic [7:0]       tprod;
   logic [OFF_W-1:0] b0;
   logic [OFF_W-1:0] bk;
   logic [2:0]       ovb;
   logic [2:0]       bofs;
   logic [23:0]      shifted;
   logic [14:0]      mask;
   logic             rovf;
   logic [4:0]       kk;
   logic signed [13:0] xx, yy;
   logic             yok;
   logic             issue;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign b0       = rowbit_ff >> 3;
   assign bofs     = rowbit_ff[2:0];

   // Row assembly: window of three bytes, shifted to the row's first bit.
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         ovb[b] = (32'(b0) + b >= GLYPH_BYTES);
      end
      shifted = win_ff >> bofs;
      mask    = 15'd0;
      rovf    = 1'b0;
      yy      = $signed({py_ff[12], py_ff}) + $signed({10'd0, dy_ff});
      yok     = (yy >= 0) && (yy < $signed({2'b00, sh_ff}));
      for (int dx = 0; dx < 15; dx++) begin
         kk = 5'(({2'b00, bofs} + 5'(dx)) >> 3);
         xx = $signed({px_ff[12], px_ff}) + 14'(dx);
         if (4'(dx) < size_ff[3:0]) begin
            if (ovb[kk[1:0]]) begin
               rovf = 1'b1;
            end else if (shifted[dx] && yok && xx >= 0 &&
                         xx < $signed({2'b00, sw_ff})) begin
               mask[dx] = 1'b1;
            end
         end
      end
   end

   assign tprod = {4'd0, size_look_w(s_rdata)} * {4'd0, size_look_h(s_rdata)};

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      slot_in    = slot_ff;
      ch_in      = ch_ff;
      code_ok_in = code_ok_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      color_in   = color_ff;
      size_in    = size_ff;
      i_in       = i_ff;
      pend_in    = 1'b0;
      off_in     = off_ff;
      rowbit_in  = rowbit_ff;
      dy_in      = dy_ff;
      k_in       = k_ff;
      win_in     = win_ff;
      ov_in      = rsp_tvalid && !rsp_tready;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      om_in      = om_ff;
      oc_in      = oc_ff;
      ol_in      = ol_ff;
      oo_in      = oo_ff;
      s_we       = 1'b0;
      s_addr     = size_addr(slot_ff, ch_ff);
      s_wdata    = 8'd0;
      g_we       = 1'b0;
      g_addr     = glyph_addr(slot_ff, GADDR_W'(b0));
      bstat.pop  = 1'b0;
      bstat.busy_clear = (state_ff == ST_CLEAR);
      s_look     = 8'd0;
      issue      = 1'b0;
      bk         = '0;

      case (state_ff)
         ST_CLEAR: begin
            s_we   = 1'b1;
            s_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == SIZE_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (qout.valid) begin
               bstat.pop = 1'b1;
               case (qout.ent.kind)
                  KIND_SIZE: begin
                     s_we    = 1'b1;
                     s_addr  = size_addr(qout.ent.font_slot, qout.ent.char_code);
                     s_wdata = qout.ent.size_byte;
                  end
                  KIND_GLYPH: begin
                     g_we   = 1'b1;
                     g_addr = glyph_addr(qout.ent.font_slot,
                                         GADDR_W'(qout.ent.glyph_addr));
                  end
                  KIND_DRAW: begin
                     s_addr     = size_addr(qout.ent.font_slot, qout.ent.char_code);
                     slot_in    = qout.ent.font_slot;
                     ch_in      = qout.ent.char_code;
                     code_ok_in = (32'(qout.ent.char_code) < CHAR_COUNT);
                     px_in      = qout.ent.pos_x;
                     py_in      = qout.ent.pos_y;
                     color_in   = qout.ent.color;
                     state_in   = ST_LOOK1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOK1: begin
            s_look = code_ok_ff ? s_rdata : 8'd0;
            if (glyph_present(s_look)) begin
               size_in  = s_look;
               i_in     = 9'd0;
               off_in   = '0;
               state_in = ST_SUM;
            end else begin
               ch_in      = unk_ff;
               code_ok_in = (32'(unk_ff) < CHAR_COUNT);
               s_addr     = size_addr(slot_ff, unk_ff);
               state_in   = ST_LOOK2;
            end
         end
         ST_LOOK2: begin
            s_look = code_ok_ff ? s_rdata : 8'd0;
            if (glyph_present(s_look)) begin
               size_in  = s_look;
               i_in     = 9'd0;
               off_in   = '0;
               state_in = ST_SUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            issue  = (i_ff < {1'b0, ch_ff});
            s_addr = size_addr(slot_ff, 8'(i_ff[CIDX_W-1:0]));
            if (issue) begin
               i_in    = i_ff + 9'd1;
               pend_in = 1'b1;
            end
            if (pend_ff && glyph_present(s_rdata)) begin
               off_in = off_ff + OFF_W'({tprod[7:3], 3'b000}) + OFF_W'(BYTE_BITS);
            end
            if (!issue && !pend_ff) begin
               rowbit_in = off_ff;
               dy_in     = 4'd0;
               k_in      = 2'd0;
               state_in  = ST_ROW;
            end
         end
         ST_ROW: begin
            bk     = b0 + OFF_W'(k_ff);
            g_addr = glyph_addr(slot_ff, GADDR_W'(bk));
            if (k_ff != 2'd0) begin
               win_in[8*(k_ff-2'd1) +: 8] = g_rdata;
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               ox_in = px_ff;
               oy_in = 14'(yy);
               om_in = mask;
               oc_in = color_ff;
               ol_in = (dy_ff == size_ff[7:4] - 4'd1);
               oo_in = rovf;
               dy_in     = dy_ff + 4'd1;
               rowbit_in = rowbit_ff + OFF_W'(size_ff[3:0]);
               k_in      = 2'd0;
               state_in  = (dy_ff == size_ff[7:4] - 4'd1) ? ST_IDLE : ST_ROW;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         rsp_tvalid <= 1'b0;
         sw_ff    <= 12'd320;
         sh_ff    <= 12'd200;
         unk_ff   <= 8'd63;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         pend_ff    <= pend_in;
         rsp_tvalid <= ov_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  sw_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: sh_ff  <= csr_wdata;
               CSR_UNKNOWN_CHAR:  unk_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      slot_ff    <= slot_in;
      ch_ff      <= ch_in;
      code_ok_ff <= code_ok_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      color_ff   <= color_in;
      size_ff    <= size_in;
      i_ff       <= i_in;
      off_ff     <= off_in;
      rowbit_ff  <= rowbit_in;
      dy_ff      <= dy_in;
      k_ff       <= k_in;
      win_ff     <= win_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      om_ff      <= om_in;
      oc_ff      <= oc_in;
      ol_ff      <= ol_in;
      oo_ff      <= oo_in;
   end

   assign rsp_tdata = {6'd0, oc_ff, om_ff, oy_ff, ox_ff};
   assign rsp_tlast = ol_ff;
   assign rsp_tuser = oo_ff;

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_tvalid) else $error("response during clear");
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (i_ff <= {1'b0, ch_ff})) else $error("walk overran");
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW || state_ff == ST_EMIT) |-> (dy_ff < size_ff[7:4]))
      else $error("row count overran");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> rsp_tvalid)
      else $error("row not presented");

endmodule
`default_nettype wire
